FILE: hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/ctps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ctps_pkg;

    localparam int MAX_SLOTS_DEF    = 64;
    localparam int TASK_ID_BITS_DEF = 8;

    localparam int TIME_W  = 63;
    localparam int DUR_W   = 32;
    localparam int CNT_W   = 7;
    localparam int FLEN_W  = 62;
    localparam int RETRY_W = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 62;

    localparam logic [RETRY_W-1:0] RETRY_RESET = 32'd30000000;
    localparam logic [TIME_W-1:0]  TIME_MAX    = {TIME_W{1'b1}};

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_PERIOD = 2'd2;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_DECIDE = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [5:0]        slot_index;
        logic [DUR_W-1:0]  slot_duration;
        logic [7:0]        slot_task;
        logic [TIME_W-1:0] current_time;
        logic [63:0]       runnable_mask;
        logic              tasklet_pending;
    } t_in_item;

    typedef struct packed {
        logic              status;
        logic              run_task;
        logic [7:0]        task_out;
        logic [CNT_W-1:0]  active_slot;
        logic [TIME_W-1:0] slice_time;
    } t_out_item;

    // slot table port controls
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_tbl_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RESTART,
        S_WALK,
        S_TAIL,
        S_DONE
    } t_state;

    // time sum clipped to the largest time
    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ctps_slot_table.sv
`timescale 1ns / 1ps
`default_nettype none

// Slot table: one write port, one read port, registered read data.
module ctps_slot_table #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 40
) (
    input  wire                     i_clk,
    input  ctps_pkg::t_tbl_ctl      i_ctl,
    input  wire [AW-1:0]            i_waddr,
    input  wire [DW-1:0]            i_wdata,
    input  wire [AW-1:0]            i_raddr,
    output logic [DW-1:0]           o_rdata
);
    import ctps_pkg::*;

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hw/rtl/cyclic_time_partition_scheduler.sv
// Cyclic time-partition scheduler, table driven.
// Input channel (i_in_valid / o_in_ready / i_in_data): one item per transfer.
//   A load item writes one slot (duration, task id) of the schedule table;
//   a decide item carries the present time, the runnable mask and the
//   tasklet flag, and asks which task runs now and for how long.
// Output channel (o_out_valid / i_out_ready / o_out_data): one result per
//   item, in order, held in an output register until transferred.
// Config port (i_cfg_we / i_cfg_index / i_cfg_wdata): single-cycle writes of
//   slot_count, frame_length and empty_retry_period; any of them also clears
//   the frame end so the next decision restarts the frame. Write while idle.
// Path to the output register: a load goes to S_DONE; a decision passes
//   S_RESTART on a frame restart and S_WALK while stepping expired slots,
//   then S_TAIL and S_DONE. The step loop does one slot table read per cycle.
// o_in_ready is high only while the core is idle; a new item can be taken
//   while the previous result still sits in the output register. If the
//   receiver stalls with a result pending, the next result waits in the core
//   and input stays blocked.
// Reset (synchronous, active low): config to defaults, slot 0, times zero.
//   Table contents are not cleared: an unloaded slot reads as garbage.
`timescale 1ns / 1ps
`default_nettype none

module cyclic_time_partition_scheduler #(
    parameter int MAX_SLOTS    = ctps_pkg::MAX_SLOTS_DEF,
    parameter int TASK_ID_BITS = ctps_pkg::TASK_ID_BITS_DEF
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_in_valid,
    output logic                                  o_in_ready,
    input  ctps_pkg::t_in_item                    i_in_data,
    output logic                                  o_out_valid,
    input  wire                                   i_out_ready,
    output ctps_pkg::t_out_item                   o_out_data,
    input  wire                                   i_cfg_we,
    input  wire [ctps_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire [ctps_pkg::CFG_DATA_W-1:0]        i_cfg_wdata
);
    import ctps_pkg::*;

    localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int TB = TASK_ID_BITS;
    localparam int DW = DUR_W + TB;

    // state and config
    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_slot_count;
    logic [FLEN_W-1:0]   r_frame_length;
    logic [RETRY_W-1:0]  r_retry;
    logic [CNT_W-1:0]    r_cur, n_cur;       // current slot
    logic [TIME_W-1:0]   r_ns, n_ns;         // next switch time
    logic [TIME_W-1:0]   r_fe, n_fe;         // frame end
    t_out_item           r_res, n_res;       // finished result, waiting for out reg

    // decision operands latched at transfer
    logic [TIME_W-1:0]   r_now;
    logic [63:0]         r_mask;
    logic                r_tasklet;

    logic                r_out_valid;
    t_out_item           r_out_data;

    // table access
    t_tbl_ctl            tbl_ctl;
    logic [CNT_W-1:0]    rd_slot;
    logic [AW+CNT_W-1:0] rd_slot_ext;
    logic [AW-1:0]       rd_addr;
    logic [AW+5:0]       wr_idx_ext;
    logic [AW-1:0]       wr_addr;
    logic [TB+7:0]       task_in_ext;
    logic [DW-1:0]       wr_data;
    logic [DW-1:0]       rd_data;
    logic [DUR_W-1:0]    rd_dur;
    logic [TB-1:0]       rd_task;
    logic [TB+7:0]       task_out_ext;

    logic                in_xfer;
    logic                load_reject;
    logic                out_load;
    logic [CNT_W-1:0]    w_count;
    logic [CNT_W-1:0]    cur_inc;
    logic [TIME_W-1:0]   walk_sum;
    logic [TIME_W-1:0]   tail_ns;
    logic [TIME_W:0]     slice_diff;
    logic                tail_past;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign out_load   = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // slot count clipped to the table depth
    assign w_count = (32'(r_slot_count) > MAX_SLOTS) ? CNT_W'(MAX_SLOTS) : r_slot_count;
    assign cur_inc = r_cur + 7'd1;

    assign load_reject = (32'(i_in_data.slot_index) >= MAX_SLOTS) ||
                         (i_in_data.slot_duration == '0);

    // address and task-width adaptation
    assign rd_slot_ext  = {{AW{1'b0}}, rd_slot};
    assign rd_addr      = rd_slot_ext[AW-1:0];
    assign wr_idx_ext   = {{AW{1'b0}}, i_in_data.slot_index};
    assign wr_addr      = wr_idx_ext[AW-1:0];
    assign task_in_ext  = {{TB{1'b0}}, i_in_data.slot_task};
    assign wr_data      = {i_in_data.slot_duration, task_in_ext[TB-1:0]};
    assign rd_dur       = rd_data[DW-1:TB];
    assign rd_task      = rd_data[TB-1:0];
    assign task_out_ext = {8'b0, rd_task};

    // one slot step: accumulate the next slot's budget
    assign walk_sum = sat_add(r_ns, TIME_W'(rd_dur));

    // result time: past the last slot the frame end is the next switch
    assign tail_past  = (r_cur >= w_count);
    assign tail_ns    = tail_past ? r_fe : r_ns;
    assign slice_diff = {1'b0, tail_ns} - {1'b0, r_now};

    ctps_slot_table #(
        .DEPTH (MAX_SLOTS),
        .AW    (AW),
        .DW    (DW)
    ) u_table (
        .i_clk   (i_clk),
        .i_ctl   (tbl_ctl),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // next state and table control
    always_comb begin
        n_state = r_state;
        n_cur   = r_cur;
        n_ns    = r_ns;
        n_fe    = r_fe;
        n_res   = r_res;
        tbl_ctl = '0;
        rd_slot = r_cur;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (i_in_data.opcode == OP_LOAD) begin
                        tbl_ctl.wr_en = !load_reject;
                        n_res         = '0;
                        n_res.status  = load_reject;
                        n_state       = S_DONE;
                    end else if (w_count == '0) begin
                        // empty table: idle for the retry period
                        n_fe    = sat_add(i_in_data.current_time, TIME_W'(r_retry));
                        n_state = S_TAIL;
                    end else if (i_in_data.current_time >= r_fe) begin
                        // frame over: restart at slot 0
                        n_cur         = '0;
                        n_fe          = sat_add(i_in_data.current_time,
                                                TIME_W'(r_frame_length));
                        rd_slot       = '0;
                        tbl_ctl.rd_en = 1'b1;
                        n_state       = S_RESTART;
                    end else if ((i_in_data.current_time >= r_ns) && (r_cur < w_count)) begin
                        n_cur = cur_inc;
                        if (cur_inc < w_count) begin
                            rd_slot       = cur_inc;
                            tbl_ctl.rd_en = 1'b1;
                            n_state       = S_WALK;
                        end else begin
                            n_state = S_TAIL;
                        end
                    end else begin
                        tbl_ctl.rd_en = 1'b1;
                        n_state       = S_TAIL;
                    end
                end
            end
            S_RESTART: begin
                // read data keeps slot 0's task for the tail
                n_ns    = sat_add(r_now, TIME_W'(rd_dur));
                n_state = S_TAIL;
            end
            S_WALK: begin
                n_ns = walk_sum;
                if (r_now >= walk_sum) begin
                    n_cur = cur_inc;
                    if (cur_inc < w_count) begin
                        rd_slot       = cur_inc;
                        tbl_ctl.rd_en = 1'b1;
                    end else begin
                        n_state = S_TAIL;
                    end
                end else begin
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                n_res        = '0;
                n_res.status = 1'b0;
                if (tail_past) begin
                    n_cur = w_count;
                    n_ns  = r_fe;
                    n_res.active_slot = w_count;
                end else begin
                    n_res.active_slot = r_cur;
                    n_res.run_task    = !r_cur[CNT_W-1] && r_mask[r_cur[5:0]] && !r_tasklet;
                    if (n_res.run_task) begin
                        n_res.task_out = task_out_ext[7:0];
                    end
                end
                n_res.slice_time = slice_diff[TIME_W] ? '0 : slice_diff[TIME_W-1:0];
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_slot_count   <= '0;
            r_frame_length <= '0;
            r_retry        <= RETRY_RESET;
            r_cur          <= '0;
            r_ns           <= '0;
            r_fe           <= '0;
        end else begin
            r_state <= n_state;
            r_cur   <= n_cur;
            r_ns    <= n_ns;
            r_fe    <= n_fe;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_SLOT_COUNT: begin
                        r_slot_count <= i_cfg_wdata[CNT_W-1:0];
                        r_fe         <= '0;
                    end
                    CFG_FRAME_LENGTH: begin
                        r_frame_length <= i_cfg_wdata[FLEN_W-1:0];
                        r_fe           <= '0;
                    end
                    CFG_RETRY_PERIOD: begin
                        r_retry <= i_cfg_wdata[RETRY_W-1:0];
                        r_fe    <= '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // operands and result payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_now     <= i_in_data.current_time;
            r_mask    <= i_in_data.runnable_mask;
            r_tasklet <= i_in_data.tasklet_pending;
        end
        r_res <= n_res;
        if (out_load) begin
            r_out_data <= r_res;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

FILE: hw/rtl/ctps_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ctps_checker (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    input  wire                  o_in_ready,
    input  wire                  o_out_valid,
    input  wire                  i_out_ready,
    input  ctps_pkg::t_out_item  o_out_data
);
    import ctps_pkg::*;

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid, "result dropped while stalled")
    `ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "second item taken while busy")
    `ASSERT_IMPLIES(a_reject_clean, i_clk, i_rst_n, o_out_valid && o_out_data.status, !o_out_data.run_task && (o_out_data.task_out == '0) && (o_out_data.active_slot == '0) && (o_out_data.slice_time == '0), "rejected load carries decision fields")
    `ASSERT_IMPLIES(a_idle_task_zero, i_clk, i_rst_n, o_out_valid && !o_out_data.run_task, o_out_data.task_out == '0, "idle result names a task")

endmodule

bind cyclic_time_partition_scheduler ctps_checker u_ctps_checker (.*);

`default_nettype wire

FILE: tb/cyclic_time_partition_scheduler_test.sv
`timescale 1ns / 1ps

module cyclic_time_partition_scheduler_test;
    import ctps_pkg::*;

    localparam int STALL_LIMIT   = 4000;  // cycles with no transfer on either side
    localparam int SETTLE_CYCLES = 80;    // above the worst slot walk
    localparam int HOLD_CYCLES   = 400;   // long receiver back-pressure
    localparam int PHASES        = 16;
    localparam int PHASE_ITEMS   = 88;

    // register index past the end of the list; a write there must do nothing
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam logic [63:0]         ALL_ONES  = '1;
    localparam logic [FLEN_W-1:0]   FRAME_MAX = '1;
    localparam t_out_item LOAD_OK     = '0;
    localparam t_out_item LOAD_REJECT = '{status: 1'b1, default: '0};
    localparam t_out_item NO_CHECK    = '0;

    typedef enum logic [1:0] {ROW_LOAD, ROW_DECIDE, ROW_REG} row_kind_e;

    // One directed step. value: duration (load), time (decide) or register data.
    // Slot/register index shares one column.
    typedef struct packed {
        row_kind_e   kind;
        logic [5:0]  index;
        logic [63:0] value;
        logic [63:0] mask;
        logic [7:0]  task_id;
        logic        tasklet;
        logic        typed;
        t_out_item   want;
    } script_row_t;

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_in_item              in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    cyclic_time_partition_scheduler dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Scheduler shadow: registers, slot memories and frame position
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]   cfg_slots = '0;
    logic [FLEN_W-1:0]  cfg_frame = '0;
    logic [RETRY_W-1:0] cfg_retry = RETRY_RESET;
    logic [DUR_W-1:0]   dur_mem  [MAX_SLOTS_DEF];
    logic [7:0]         task_mem [MAX_SLOTS_DEF];
    int unsigned        cur_slot  = 0;
    logic [TIME_W-1:0]  next_sw   = '0;
    logic [TIME_W-1:0]  frame_end = '0;

    // Results expected back, oldest first.
    t_out_item pending_results[$];

    int  mismatch_count = 0;
    int  result_index   = 0;
    int  quiet_cycles   = 0;
    int  hold_request   = 0;   // set by stimulus, consumed by the receiver
    bit  calm           = 1'b0; // no idling on either side while set

    // stimulus knobs
    int unsigned       dur_scale = 50;
    int unsigned       step_max  = 50;
    logic [TIME_W-1:0] sim_now   = '0;

    script_row_t script [31] = '{
        // empty table: idle for the retry period, saturating at the top of time
        '{ROW_DECIDE, 6'd0, 64'd0, 64'd0, 8'h00, 1'b0, 1'b1,
          '{1'b0, 1'b0, 8'h00, 7'd0, 63'd30000000}},
        '{ROW_DECIDE, 6'd0, {1'b0, TIME_MAX}, ALL_ONES, 8'h00, 1'b1, 1'b1,
          '{1'b0, 1'b0, 8'h00, 7'd0, 63'd0}},
        '{ROW_DECIDE, 6'd0, 64'd1000, ALL_ONES, 8'h00, 1'b0, 1'b1,
          '{1'b0, 1'b0, 8'h00, 7'd0, 63'd30000000}},
        // zero duration is rejected, at both ends of the index range
        '{ROW_LOAD, 6'd0,  64'd0, 64'd0, 8'hA5, 1'b0, 1'b1, LOAD_REJECT},
        '{ROW_LOAD, 6'd63, 64'd0, 64'd0, 8'hFF, 1'b0, 1'b1, LOAD_REJECT},
        '{ROW_LOAD, 6'd0,  64'd100, 64'd0, 8'h11, 1'b0, 1'b1, LOAD_OK},
        '{ROW_LOAD, 6'd1,  64'd1, 64'd0, 8'hFF, 1'b0, 1'b1, LOAD_OK},
        '{ROW_LOAD, 6'd2,  64'hFFFF_FFFF, 64'd0, 8'h00, 1'b0, 1'b1, LOAD_OK},
        '{ROW_LOAD, 6'd3,  64'd50, 64'd0, 8'h80, 1'b0, 1'b1, LOAD_OK},
        '{ROW_LOAD, 6'd63, 64'd7, 64'd0, 8'h3C, 1'b0, 1'b1, LOAD_OK},
        // four slots, 1000 ns frame: restart, step, masked slot, tasklet, wrap
        '{ROW_REG, 6'(CFG_SLOT_COUNT), 64'd4, 64'd0, 8'h00, 1'b0, 1'b0, NO_CHECK},
        '{ROW_REG, 6'(CFG_FRAME_LENGTH), 64'd1000, 64'd0, 8'h00, 1'b0, 1'b0, NO_CHECK},
        '{ROW_DECIDE, 6'd0, 64'd5000, ALL_ONES, 8'h00, 1'b0, 1'b0, NO_CHECK},
        '{ROW_DECIDE, 6'd0, 64'd5100, ALL_ONES, 8'h00, 1'b0, 1'b0, NO_CHECK},
        '{ROW_DECIDE, 6'd0, 64'd5101, ~64'h4, 8'h00, 1'b0, 1'b0, NO_CHECK},
        '{ROW_DECIDE, 6'd0, 64'd5102, ALL_ONES, 8'h00, 1'b1, 1'b0, NO_CHECK},
        '{ROW_DECIDE, 6'd0, 64'd6000, ALL_ONES, 8'h00, 1'b0, 1'b0, NO_CHECK},
        // out-of-list register: frame must not restart
        '{ROW_REG, 6'(CFG_UNUSED), 64'd5, 64'd0, 8'h00, 1'b0, 1'b0, NO_CHECK},
        '{ROW_DECIDE, 6'd0, 64'd6100, 64'd0, 8'h00, 1'b0, 1'b0, NO_CHECK},
        // one slot, longest frame, times near the top: saturation
        '{ROW_REG, 6'(CFG_SLOT_COUNT), 64'd1, 64'd0, 8'h00, 1'b0, 1'b0, NO_CHECK},
        '{ROW_REG, 6'(CFG_FRAME_LENGTH), 64'(FRAME_MAX), 64'd0, 8'h00, 1'b0, 1'b0,
          NO_CHECK},
        '{ROW_DECIDE, 6'd0, 64'(TIME_MAX) - 64'd50, ALL_ONES, 8'h00, 1'b0, 1'b0,
          NO_CHECK},
        '{ROW_DECIDE, 6'd0, 64'(TIME_MAX), ALL_ONES, 8'h00, 1'b0, 1'b0, NO_CHECK},
        // zero frame: every decision restarts
        '{ROW_REG, 6'(CFG_FRAME_LENGTH), 64'd0, 64'd0, 8'h00, 1'b0, 1'b0, NO_CHECK},
        '{ROW_DECIDE, 6'd0, 64'd10, ALL_ONES, 8'h00, 1'b0, 1'b0, NO_CHECK},
        '{ROW_DECIDE, 6'd0, 64'd10, ALL_ONES, 8'h00, 1'b0, 1'b0, NO_CHECK},
        // retry period extremes on an empty table
        '{ROW_REG, 6'(CFG_SLOT_COUNT), 64'd0, 64'd0, 8'h00, 1'b0, 1'b0, NO_CHECK},
        '{ROW_REG, 6'(CFG_RETRY_PERIOD), 64'd1, 64'd0, 8'h00, 1'b0, 1'b0, NO_CHECK},
        '{ROW_DECIDE, 6'd0, 64'd7, 64'd0, 8'h00, 1'b0, 1'b1,
          '{1'b0, 1'b0, 8'h00, 7'd0, 63'd1}},
        '{ROW_REG, 6'(CFG_RETRY_PERIOD), 64'hFFFF_FFFF, 64'd0, 8'h00, 1'b0, 1'b0,
          NO_CHECK},
        '{ROW_DECIDE, 6'd0, 64'd0, ALL_ONES, 8'h00, 1'b0, 1'b1,
          '{1'b0, 1'b0, 8'h00, 7'd0, 63'hFFFF_FFFF}}
    };

    function automatic logic [TIME_W-1:0] time_sum(input logic [TIME_W-1:0] a,
                                                   input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = a + b;
        return (s > {1'b0, TIME_MAX}) ? TIME_MAX : s[TIME_W-1:0];
    endfunction

    // Register write as seen by the shadow; listed registers restart the frame.
    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_SLOT_COUNT: begin
                cfg_slots = data[CNT_W-1:0];
                frame_end = '0;
            end
            CFG_FRAME_LENGTH: begin
                cfg_frame = data[FLEN_W-1:0];
                frame_end = '0;
            end
            CFG_RETRY_PERIOD: begin
                cfg_retry = data[RETRY_W-1:0];
                frame_end = '0;
            end
            default: ;
        endcase
    endfunction

    // Next dispatch for one transfer; updates the shadow state.
    function automatic t_out_item predict_schedule(input t_in_item it);
        t_out_item         r;
        int unsigned       count;
        logic              run;
        logic [TIME_W-1:0] t_now;
        r     = '0;
        t_now = it.current_time;
        if (it.opcode == OP_LOAD) begin
            r.status = (it.slot_duration == '0);
            if (!r.status) begin
                dur_mem[it.slot_index]  = it.slot_duration;
                task_mem[it.slot_index] = it.slot_task;
            end
            return r;
        end
        count = (cfg_slots > MAX_SLOTS_DEF) ? MAX_SLOTS_DEF : cfg_slots;
        if (count == 0) begin
            frame_end = time_sum(t_now, cfg_retry);
        end else if (t_now >= frame_end) begin
            cur_slot  = 0;
            frame_end = time_sum(t_now, cfg_frame);
            next_sw   = time_sum(t_now, dur_mem[0]);
        end else begin
            // step past every slot whose switch time has gone by
            while (t_now >= next_sw && cur_slot < count) begin
                cur_slot++;
                if (cur_slot < count)
                    next_sw = time_sum(next_sw, dur_mem[cur_slot]);
            end
        end
        if (cur_slot >= count) begin
            // frame tail: idle until the frame ends
            cur_slot = count;
            next_sw  = frame_end;
        end else begin
            run        = it.runnable_mask[cur_slot] && !it.tasklet_pending;
            r.run_task = run;
            if (run)
                r.task_out = task_mem[cur_slot];
        end
        r.active_slot = CNT_W'(cur_slot);
        r.slice_time  = (next_sw > t_now) ? next_sw - t_now : '0;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_in_item random_bits();
        logic [191:0] pool;
        pool = {rand64(), rand64(), rand64()};
        return pool[$bits(t_in_item)-1:0];
    endfunction

    function automatic t_in_item make_load();
        t_in_item    it;
        int unsigned r;
        it        = random_bits();
        it.opcode = OP_LOAD;
        r         = $urandom_range(99);
        if (r < 3)
            it.slot_duration = '0;                         // rejected
        else if (r < 13)
            it.slot_duration = $urandom_range(1, 8);
        else if (r < 97)
            it.slot_duration = $urandom_range(1, dur_scale);
        else if (r < 99)
            it.slot_duration = $urandom;                  // full width
        else
            it.slot_duration = '1;
        return it;
    endfunction

    // Mostly a time walking forward in steps near the slot durations.
    function automatic t_in_item make_decide();
        t_in_item    it;
        int unsigned r;
        it        = random_bits();
        it.opcode = OP_DECIDE;
        r         = $urandom_range(99);
        if (r < 78)
            sim_now = time_sum(sim_now, $urandom_range(0, step_max));
        else if (r < 88)
            sim_now = time_sum(sim_now, $urandom_range(0, 64 * dur_scale + 2000));
        else if (r < 93)
            sim_now = sim_now;                            // same time again
        else if (r < 97)
            sim_now = TIME_W'(rand64());
        else
            sim_now = (sim_now > 500) ? sim_now - $urandom_range(0, 500) : '0;
        it.current_time    = sim_now;
        it.tasklet_pending = ($urandom_range(99) < 10);
        r = $urandom_range(99);
        if (r < 25)
            it.runnable_mask = ALL_ONES;
        else if (r < 40)
            it.runnable_mask = rand64() & rand64();
        return it;
    endfunction

    function automatic logic [FLEN_W-1:0] pick_frame(input int unsigned slots);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 8)
            return '0;
        else if (r < 16)
            return FRAME_MAX;
        else if (r < 24)
            return FLEN_W'(rand64());
        return $urandom_range(1, slots * dur_scale + 200);
    endfunction

    function automatic logic [RETRY_W-1:0] pick_retry();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 20)
            return 1;
        else if (r < 40)
            return '1;
        else if (r < 70)
            return $urandom_range(1, 100000);
        return $urandom | 32'd1;
    endfunction

    // Random sender gap; valid drops only here and before a drain.
    task automatic sender_gap();
        if (!calm && $urandom_range(99) < 7) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Offer one item and hold it until the transfer; log what should come back.
    task automatic offer_item(input t_in_item it, input logic typed,
                              input t_out_item want);
        t_out_item guess;
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!in_ready);
        guess = predict_schedule(it);
        pending_results.push_back(typed ? want : guess);
    endtask

    // Stop sending and wait for every outstanding result.
    task automatic await_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        apply_register(idx, data);
        @(posedge clk);
    endtask

    // Every slot gets a short random duration so any slot count is safe to read.
    task automatic fill_schedule();
        t_in_item it;
        for (int i = 0; i < MAX_SLOTS_DEF; i++) begin
            it               = make_load();
            it.slot_index    = i;
            it.slot_duration = $urandom_range(1, dur_scale);
            sender_gap();
            offer_item(it, 1'b0, NO_CHECK);
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        int n;
        forever begin
            @(posedge clk);
            if (hold_request != 0) begin
                out_ready    <= 1'b0;
                n            = hold_request;
                hold_request = 0;
                repeat (n) @(posedge clk);
            end else begin
                out_ready <= calm || ($urandom_range(99) >= 7);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: in-order compare against the oldest expectation
    // ------------------------------------------------------------------
    t_out_item oldest;

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("result %h arrived with nothing outstanding", out_data);
            end else begin
                oldest = pending_results.pop_front();
                if (out_data.status      !== oldest.status      ||
                    out_data.run_task    !== oldest.run_task    ||
                    out_data.task_out    !== oldest.task_out    ||
                    out_data.active_slot !== oldest.active_slot ||
                    out_data.slice_time  !== oldest.slice_time) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"result %0d mismatch (exp/got): status %0b/%0b ",
                                  "run %0b/%0b task %02h/%02h slot %0d/%0d ",
                                  "slice %0d/%0d"},
                                 result_index,
                                 oldest.status, out_data.status,
                                 oldest.run_task, out_data.run_task,
                                 oldest.task_out, out_data.task_out,
                                 oldest.active_slot, out_data.active_slot,
                                 oldest.slice_time, out_data.slice_time);
                end
            end
            result_index++;
        end
    end

    // Watchdog: too long without any transfer means the block is hung.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    int unsigned slot_plan [PHASES] = '{8, 4, 64, 1, 127, 0, 16, 2,
                                        64, 33, 100, 5, 64, 3, 12, 64};

    initial begin
        t_in_item    stim;
        logic [63:0] word;
        int unsigned pick;
        int unsigned slots;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows
        foreach (script[r]) begin
            if (script[r].kind == ROW_REG) begin
                await_idle();
                write_reg(script[r].index[CFG_IDX_W-1:0], script[r].value[CFG_DATA_W-1:0]);
            end else begin
                stim = random_bits();   // fields the operation ignores stay random
                if (script[r].kind == ROW_LOAD) begin
                    stim.opcode        = OP_LOAD;
                    stim.slot_index    = script[r].index;
                    stim.slot_duration = script[r].value[DUR_W-1:0];
                    stim.slot_task     = script[r].task_id;
                end else begin
                    stim.opcode          = OP_DECIDE;
                    stim.current_time    = script[r].value[TIME_W-1:0];
                    stim.runnable_mask   = script[r].mask;
                    stim.tasklet_pending = script[r].tasklet;
                end
                sender_gap();
                offer_item(stim, script[r].typed, script[r].want);
            end
        end

        // random phases, each with its own register setting
        for (int p = 0; p < PHASES; p++) begin
            calm = (p == 2);   // one long stretch without any idling
            case ($urandom_range(2))
                0: dur_scale = 8;
                1: dur_scale = 50;
                default: dur_scale = 300;
            endcase
            step_max = dur_scale;
            if (p == 0 || p == 8)
                fill_schedule();

            await_idle();
            slots = slot_plan[p];
            word = rand64();           // upper bits are don't-care
            word[CNT_W-1:0] = slots;
            write_reg(CFG_SLOT_COUNT, word[CFG_DATA_W-1:0]);
            if (p == 0 || $urandom_range(1) == 1)
                write_reg(CFG_FRAME_LENGTH,
                          pick_frame(slots > MAX_SLOTS_DEF ? MAX_SLOTS_DEF : slots));
            if (p == 0 || $urandom_range(3) == 0) begin
                word = rand64();
                word[RETRY_W-1:0] = pick_retry();
                write_reg(CFG_RETRY_PERIOD, word[CFG_DATA_W-1:0]);
            end
            if ($urandom_range(4) != 0)
                sim_now = $urandom_range(0, 100000);

            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // receiver holds off while the sender keeps pushing
                if (p == 4 && k == 10)
                    hold_request = HOLD_CYCLES;
                // sender pauses mid-phase until everything has drained
                if (p == 6 && k == PHASE_ITEMS / 2)
                    await_idle();
                pick = $urandom_range(99);
                if (pick < 10)
                    stim = make_load();
                else if (pick < 14)
                    stim = random_bits();
                else
                    stim = make_decide();
                sender_gap();
                offer_item(stim, 1'b0, NO_CHECK);
            end
        end

        await_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
